>>> rtl/csll_pkg.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup package
// Shared constants and types for the schedule limit lookup block.
// ----------------------------------------------------------------------------
package csll_pkg;

   localparam int MaxPeriodsDefault = 32;
   localparam int CsrIdxWidth       = 3;
   localparam int CsrDataWidth      = 32;
   localparam int StartWidth        = 31;
   localparam int LimitWidth        = 24;
   localparam int TimeWidth         = 32;
   localparam int ReqDataWidth      = 128;
   localparam int RspDataWidth      = 64;

   localparam logic [TimeWidth-1:0] TimeNever   = 32'hFFFF_FFFF;
   localparam logic [TimeWidth-1:0] DaySeconds  = 32'd86400;
   localparam logic [TimeWidth-1:0] WeekSeconds = 32'd604800;

   // Floor of 2**32 divided by the day and week lengths.
   localparam logic [15:0] DayRecip  = 16'd49710;
   localparam logic [15:0] WeekRecip = 16'd7101;

   localparam logic [1:0] CmdClear  = 2'd0;
   localparam logic [1:0] CmdInsert = 2'd1;
   localparam logic [1:0] CmdQuery  = 2'd2;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoLimit = 2'd1;
   localparam logic [1:0] StatusFull    = 2'd2;

   localparam logic [1:0] KindAbsolute  = 2'd0;
   localparam logic [1:0] KindRecurring = 2'd1;
   localparam logic [1:0] KindRelative  = 2'd2;
   localparam logic [1:0] RecurWeekly   = 2'd1;

   localparam logic [CsrIdxWidth-1:0] RegProfileKind    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegRecurrence     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegScheduleStart  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegScheduleLength = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegMinRate        = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegValidFrom      = 3'd5;
   localparam logic [CsrIdxWidth-1:0] RegValidTo        = 3'd6;

   typedef struct packed {
      logic [1:0]            profile_kind;
      logic [1:0]            recurrence;
      logic [TimeWidth-1:0]  schedule_start;
      logic signed [31:0]    schedule_length;
      logic signed [24:0]    min_rate;
      logic [TimeWidth-1:0]  valid_from;
      logic [TimeWidth-1:0]  valid_to;
   } cfg_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture a new transaction
      logic clear;     // empty the table
      logic ins_step;  // one shift step of an insert
      logic ins_write; // place the new period
      logic q_prep;    // evaluate window and basis
      logic mod_step;  // one step of the remainder unit
      logic q_base;    // form basis after the modulo
      logic q_scan;    // compare one entry
      logic q_final;   // form the result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       ins_done;
      logic       prep_done;  // query result already known
      logic       need_mod;
      logic       mod_done;
      logic       scan_done;
   } stat_type;

endpackage

>>> rtl/csll_ctrl.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup controller
// Sequences clears, inserts and queries through the datapath.
// ----------------------------------------------------------------------------
module csll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   input  csll_pkg::stat_type stat,
   output csll_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      StIdle, StDecode, StInsert, StPrep, StCheck, StMod, StBase, StScan, StFinal, StOut
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign in_ready  = (state_ff == StIdle);
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         StIdle: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = StDecode;
            end
         end
         StDecode: begin
            if (stat.cmd == csll_pkg::CmdClear) begin
               cmd.clear = 1'b1;
               state_in  = StFinal;
            end else if (stat.cmd == csll_pkg::CmdInsert) begin
               state_in = stat.full ? StFinal : StInsert;
            end else if (stat.cmd == csll_pkg::CmdQuery) begin
               state_in = StPrep;
            end else begin
               state_in = StFinal;
            end
         end
         StInsert: begin
            if (stat.ins_done) begin
               cmd.ins_write = 1'b1;
               state_in      = StFinal;
            end else begin
               cmd.ins_step = 1'b1;
            end
         end
         StPrep: begin
            cmd.q_prep = 1'b1;
            state_in   = StCheck;
         end
         StCheck: begin
            if (stat.prep_done)     state_in = StFinal;
            else if (stat.need_mod) state_in = StMod;
            else                    state_in = StBase;
         end
         StMod: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = StBase;
         end
         StBase: begin
            cmd.q_base = 1'b1;
            state_in   = StScan;
         end
         StScan: begin
            if (stat.scan_done) state_in = StFinal;
            else                cmd.q_scan = 1'b1;
         end
         StFinal: begin
            cmd.q_final  = 1'b1;
            out_valid_in = 1'b1;
            state_in     = StOut;
         end
         StOut: begin
            if (out_ready) begin
               out_valid_in = 1'b0;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/csll_datapath.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup datapath
// Period table, insertion shifter, modulo unit and sequential period scan.
// ----------------------------------------------------------------------------
module csll_datapath #(
   parameter int MaxPeriods = csll_pkg::MaxPeriodsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  csll_pkg::cfg_type                  cfg,
   input  csll_pkg::cmd_type                  cmd,
   output csll_pkg::stat_type                 stat,
   input  logic [1:0]                         req_cmd,
   input  logic [csll_pkg::StartWidth-1:0]    req_start,
   input  logic [csll_pkg::LimitWidth-1:0]    req_limit,
   input  logic [csll_pkg::TimeWidth-1:0]     req_time,
   input  logic [csll_pkg::TimeWidth-1:0]     req_cs,
   output logic [1:0]                         rsp_status,
   output logic [csll_pkg::LimitWidth-1:0]    rsp_limit,
   output logic [csll_pkg::TimeWidth-1:0]     rsp_next
);

   localparam int IdxW = (MaxPeriods > 1) ? $clog2(MaxPeriods) : 1;
   localparam int CntW = $clog2(MaxPeriods + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(MaxPeriods);

   logic [csll_pkg::StartWidth-1:0] starts_mem [MaxPeriods];
   logic [csll_pkg::LimitWidth-1:0] limits_mem [MaxPeriods];

   logic [1:0]                      cmd_ff;
   logic [csll_pkg::StartWidth-1:0] pstart_ff;
   logic [csll_pkg::LimitWidth-1:0] plimit_ff;
   logic [31:0]                     t_ff, cs_ff;
   logic [CntW-1:0]                 count_ff, pos_ff, idx_ff;
   logic [32:0]                     basis_ff, nxt_ff;
   logic [31:0]                     rel_ff;
   logic [31:0]                     rem_ff, diff_ff, per_ff, qd_ff;
   logic [15:0]                     recip_ff;
   logic [47:0]                     prod_ff;
   logic [1:0]                      mod_ph_ff;
   logic                            early_ff, found_ff, stop_ff;
   logic [1:0]                      early_status_ff;
   logic [31:0]                     early_next_ff;
   logic [csll_pkg::LimitWidth-1:0] best_ff;
   logic [1:0]                      status_ff;
   logic [csll_pkg::LimitWidth-1:0] limit_ff;
   logic [31:0]                     next_ff;

   logic [IdxW-1:0] pos_idx, prev_idx, scan_idx;
   logic [32:0]     dur;
   logic [32:0]     ent_time;
   logic            len_pos;

   assign pos_idx  = pos_ff[IdxW-1:0];
   assign prev_idx = IdxW'(pos_ff - CntW'(1));
   assign scan_idx = idx_ff[IdxW-1:0];
   assign len_pos  = (cfg.schedule_length > 0);
   assign dur      = {1'b0, cfg.schedule_length};
   assign ent_time = basis_ff + {2'b0, starts_mem[scan_idx]};

   assign stat.cmd       = cmd_ff;
   assign stat.full      = (count_ff >= CntMax);
   assign stat.ins_done  = (pos_ff == '0) || (starts_mem[prev_idx] <= pstart_ff);
   assign stat.prep_done = early_ff;
   assign stat.need_mod  = (cfg.profile_kind == csll_pkg::KindRecurring);
   assign stat.mod_done  = (mod_ph_ff == 2'd3);
   assign stat.scan_done = stop_ff || (idx_ff >= count_ff);

   assign rsp_status = status_ff;
   assign rsp_limit  = limit_ff;
   assign rsp_next   = next_ff;

   always_ff @(posedge clock) begin
      if (cmd.ins_step) begin
         starts_mem[pos_idx] <= starts_mem[prev_idx];
         limits_mem[pos_idx] <= limits_mem[prev_idx];
      end else if (cmd.ins_write) begin
         starts_mem[pos_idx] <= pstart_ff;
         limits_mem[pos_idx] <= plimit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.ins_write) begin
         count_ff <= count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_cmd;
         pstart_ff <= req_start;
         plimit_ff <= req_limit;
         t_ff      <= req_time;
         cs_ff     <= req_cs;
         pos_ff    <= count_ff;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         stop_ff   <= 1'b0;
         best_ff   <= '0;
      end
      if (cmd.ins_step) pos_ff <= pos_ff - CntW'(1);

      if (cmd.q_prep) begin
         early_ff        <= 1'b0;
         early_status_ff <= csll_pkg::StatusNoLimit;
         nxt_ff          <= {1'b0, csll_pkg::TimeNever};
         per_ff          <= (cfg.recurrence == csll_pkg::RecurWeekly) ?
                            csll_pkg::WeekSeconds : csll_pkg::DaySeconds;
         recip_ff        <= (cfg.recurrence == csll_pkg::RecurWeekly) ?
                            csll_pkg::WeekRecip : csll_pkg::DayRecip;
         diff_ff         <= t_ff - cfg.schedule_start;
         rem_ff          <= '0;
         mod_ph_ff       <= '0;
         basis_ff        <= {1'b0, cs_ff};
         if (cfg.valid_to != '0 && t_ff > cfg.valid_to) begin
            early_ff <= 1'b1; early_next_ff <= csll_pkg::TimeNever;
         end else if (t_ff < cfg.valid_from) begin
            early_ff <= 1'b1; early_next_ff <= cfg.valid_from;
         end else if (cfg.profile_kind == csll_pkg::KindAbsolute) begin
            if (cfg.schedule_start > t_ff) begin
               early_ff <= 1'b1; early_next_ff <= cfg.schedule_start;
            end else if (cfg.schedule_start != '0) begin
               basis_ff <= {1'b0, cfg.schedule_start};
            end else if (!(cs_ff != '0 && cs_ff < t_ff)) begin
               early_ff <= 1'b1; early_next_ff <= csll_pkg::TimeNever;
            end
         end else if (cfg.profile_kind == csll_pkg::KindRecurring) begin
            if (t_ff < cfg.schedule_start) begin
               early_ff <= 1'b1; early_next_ff <= cfg.schedule_start;
            end
         end else if (cs_ff > t_ff) begin
            early_ff <= 1'b1; early_next_ff <= csll_pkg::TimeNever;
         end
      end

      // The quotient estimate from the reciprocal is low by at most one, so a
      // single compare and subtract finishes the remainder.
      if (cmd.mod_step) begin
         mod_ph_ff <= mod_ph_ff + 2'd1;
         case (mod_ph_ff)
            2'd0: prod_ff <= {16'b0, diff_ff} * {32'b0, recip_ff};
            2'd1: qd_ff   <= {16'b0, prod_ff[47:32]} * per_ff;
            2'd2: rem_ff  <= diff_ff - qd_ff;
            default: begin
               if (rem_ff >= per_ff) rem_ff <= rem_ff - per_ff;
            end
         endcase
      end

      if (cmd.q_base) begin
         if (cfg.profile_kind == csll_pkg::KindRecurring) begin
            basis_ff <= {1'b0, t_ff - rem_ff};
            rel_ff   <= rem_ff;
            nxt_ff   <= {1'b0, t_ff - rem_ff} + {1'b0, per_ff};
            if (len_pos) begin
               if ({1'b0, rem_ff} >= dur) begin
                  stop_ff <= 1'b1;
               end else if ({1'b0, per_ff} > dur) begin
                  nxt_ff <= {1'b0, t_ff - rem_ff} + dur;
               end
            end
         end else begin
            rel_ff <= t_ff - basis_ff[31:0];
            if (len_pos) begin
               if ({1'b0, t_ff - basis_ff[31:0]} >= dur) begin
                  stop_ff <= 1'b1;
               end else begin
                  nxt_ff <= basis_ff + dur;
               end
            end
         end
      end

      if (cmd.q_scan) begin
         if ({1'b0, starts_mem[scan_idx]} > rel_ff) begin
            nxt_ff  <= ent_time;
            stop_ff <= 1'b1;
         end else begin
            best_ff  <= limits_mem[scan_idx];
            found_ff <= 1'b1;
            idx_ff   <= idx_ff + CntW'(1);
         end
      end

      if (cmd.q_final) begin
         status_ff <= csll_pkg::StatusOk;
         limit_ff  <= '0;
         next_ff   <= '0;
         if (cmd_ff == csll_pkg::CmdInsert && count_ff >= CntMax && pos_ff == count_ff
             && !cmd.ins_write) begin
            status_ff <= csll_pkg::StatusFull;
         end else if (cmd_ff == csll_pkg::CmdQuery) begin
            if (early_ff) begin
               status_ff <= early_status_ff;
               next_ff   <= early_next_ff;
            end else begin
               next_ff <= nxt_ff[32] ? csll_pkg::TimeNever : nxt_ff[31:0];
               if (!found_ff) begin
                  status_ff <= csll_pkg::StatusNoLimit;
               end else if (cfg.min_rate > $signed({1'b0, best_ff})) begin
                  limit_ff <= cfg.min_rate[csll_pkg::LimitWidth-1:0];
               end else begin
                  limit_ff <= best_ff;
               end
            end
         end
      end
   end

endmodule

>>> rtl/csll_csr.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup register file
// Holds the profile configuration written through the plain write port.
// ----------------------------------------------------------------------------
module csll_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [csll_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [csll_pkg::CsrDataWidth-1:0]   csr_wdata,
   output csll_pkg::cfg_type                   cfg
);

   csll_pkg::cfg_type cfg_ff;

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.profile_kind    <= 2'd0;
         cfg_ff.recurrence      <= 2'd2;
         cfg_ff.schedule_start  <= '0;
         cfg_ff.schedule_length <= -32'sd1;
         cfg_ff.min_rate        <= -25'sd1;
         cfg_ff.valid_from      <= '0;
         cfg_ff.valid_to        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            csll_pkg::RegProfileKind:    cfg_ff.profile_kind    <= csr_wdata[1:0];
            csll_pkg::RegRecurrence:     cfg_ff.recurrence      <= csr_wdata[1:0];
            csll_pkg::RegScheduleStart:  cfg_ff.schedule_start  <= csr_wdata;
            csll_pkg::RegScheduleLength: cfg_ff.schedule_length <= csr_wdata;
            csll_pkg::RegMinRate:        cfg_ff.min_rate        <= csr_wdata[24:0];
            csll_pkg::RegValidFrom:      cfg_ff.valid_from      <= csr_wdata;
            csll_pkg::RegValidTo:        cfg_ff.valid_to        <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/charging_schedule_limit_lookup_top.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup
// A request transaction on req_ carries a command: clear the period table,
// insert a period (kept sorted by start offset), or query the limit that
// applies at a time. Every request gives exactly one response on rsp_.
// Requests are taken one at a time; req_tready is high only while idle.
// A clear, an unused command or a refused insert goes from decode straight
// to the response. An insert shifts each later-starting entry up one place,
// then writes the new period. A query checks the validity window and basis,
// which may settle it; else it forms its basis and compares the periods one
// by one, a recurring query first taking its remainder by the day or week
// length through a reciprocal multiply, a multiply back, a subtract and a
// final compare and subtract. The response stays in its register until
// rsp_tready takes it; req_tready rises the cycle after that. Reset empties
// the table and loads the register defaults. Configuration must be written
// through csr_ while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module charging_schedule_limit_lookup_top #(
   parameter int MaxPeriods = csll_pkg::MaxPeriodsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd[1:0], period_start[32:2], period_limit[56:33], query_time[88:57],
   // charge_start[120:89]
   input  logic [csll_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], limit_tenths[25:2], next_change[57:26]
   output logic [csll_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [csll_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [csll_pkg::CsrDataWidth-1:0]   csr_wdata
);

   csll_pkg::cfg_type  cfg;
   csll_pkg::cmd_type  cmd;
   csll_pkg::stat_type stat;
   logic [1:0]         status;
   logic [23:0]        limit;
   logic [31:0]        next;

   csll_csr u_csr (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   csll_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .stat, .cmd
   );

   csll_datapath #(.MaxPeriods(MaxPeriods)) u_dp (
      .clock, .reset, .cfg, .cmd, .stat,
      .req_cmd(req_tdata[1:0]),
      .req_start(req_tdata[32:2]),
      .req_limit(req_tdata[56:33]),
      .req_time(req_tdata[88:57]),
      .req_cs(req_tdata[120:89]),
      .rsp_status(status), .rsp_limit(limit), .rsp_next(next)
   );

   assign rsp_tdata = {6'b0, next, limit, status};

endmodule

>>> rtl/csll_checker.sv
// ----------------------------------------------------------------------------
// Charging schedule limit lookup checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module csll_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [csll_pkg::RspDataWidth-1:0]  rsp_tdata
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a response is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("illegal status code");

   a_no_lim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != csll_pkg::StatusOk |-> rsp_tdata[25:2] == '0)
      else $error("limit nonzero without a found limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after accept");

endmodule

bind charging_schedule_limit_lookup_top csll_checker u_csll_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
